// ===== rtl/fqd_pkg.sv =====
// ----------------------------------------------------------------------------
// fqd_pkg: shared types and codes of the order-keeping handle queue
// Request and response structs, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package fqd_pkg;

    localparam int FQD_DEPTH        = 16;
    localparam int FQD_HANDLE_WIDTH = 32;

    localparam int FQD_FUNC_W   = 2;
    localparam int FQD_VALUE_W  = 32;
    localparam int FQD_STATUS_W = 3;
    localparam int FQD_LEN_W    = 5;

    localparam logic [FQD_FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [FQD_FUNC_W-1:0] FUNC_DEQUEUE = 2'd1;
    localparam logic [FQD_FUNC_W-1:0] FUNC_DELETE  = 2'd2;

    localparam logic [FQD_STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [FQD_STATUS_W-1:0] ST_NULL   = 3'd1;
    localparam logic [FQD_STATUS_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [FQD_STATUS_W-1:0] ST_ABSENT = 3'd3;
    localparam logic [FQD_STATUS_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [FQD_FUNC_W-1:0]  func;
        logic [FQD_VALUE_W-1:0] data_value;
    } fqd_req_t;

    typedef struct packed {
        logic [FQD_STATUS_W-1:0] status;
        logic [FQD_VALUE_W-1:0]  out_value;
        logic [FQD_LEN_W-1:0]    fill_level;
    } fqd_rsp_t;

endpackage

// ===== rtl/fifo_queue_with_delete.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_delete: order-keeping queue of nonzero handles
// Enqueue, dequeue and delete of the oldest matching handle, with compaction.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH handles in one synchronous memory with a single
// registered read port, and works on one request at a time. A delete reads
// one entry per cycle from the front until it finds the handle, then moves
// each younger entry one place forward at one entry per cycle. The next
// request is taken as soon as the result has moved to the output register.
module fifo_queue_with_delete
    import fqd_pkg::*;
#(
    parameter int DEPTH        = FQD_DEPTH,
    parameter int HANDLE_WIDTH = FQD_HANDLE_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fqd_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fqd_rsp_t m_data
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEEP_W = (HANDLE_WIDTH < FQD_VALUE_W) ? HANDLE_WIDTH : FQD_VALUE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEQ    = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [PTR_W-1:0]        front_reg, front_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        off_reg, off_next;
    logic [HANDLE_WIDTH-1:0] handle_reg, handle_next;
    fqd_rsp_t                res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    fqd_rsp_t                m_data_reg, m_data_next;

    logic                    ram_wr_en;
    logic [PTR_W-1:0]        ram_wr_addr;
    logic [HANDLE_WIDTH-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [PTR_W-1:0]        ram_rd_addr;
    logic [HANDLE_WIDTH-1:0] ram_rd_data;

    logic [HANDLE_WIDTH-1:0] in_handle;
    logic [CNT_W-1:0]        count_dec;
    logic                    off_is_last;
    logic                    ptr_hit;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic fqd_rsp_t make_rsp(input logic [FQD_STATUS_W-1:0] st,
                                          input logic [FQD_VALUE_W-1:0]  val,
                                          input logic [CNT_W-1:0]        cnt);
        fqd_rsp_t r;
        r.status     = st;
        r.out_value  = val;
        r.fill_level = FQD_LEN_W'(cnt);
        make_rsp = r;
    endfunction

    fqd_ram #(
        .DEPTH (DEPTH),
        .WIDTH (HANDLE_WIDTH)
    ) u_fqd_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_handle   = HANDLE_WIDTH'(s_data.data_value[KEEP_W-1:0]);
    assign count_dec   = count_reg - CNT_W'(1);
    assign off_is_last = (CNT_W'(off_reg) == count_dec);
    assign ptr_hit     = (ram_rd_data == handle_reg);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        off_next     = off_reg;
        handle_next  = handle_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = wr_ptr_reg;
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = ptr_inc(ptr_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    handle_next = in_handle;
                    state_next  = S_RESP;
                    unique case (s_data.func)
                        FUNC_ENQUEUE: begin
                            if (in_handle == '0) begin
                                res_next = make_rsp(ST_NULL, '0, count_reg);
                            end else if (count_reg == CNT_W'(DEPTH)) begin
                                res_next = make_rsp(ST_FULL, '0, count_reg);
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = tail_reg;
                                ram_wr_data = in_handle;
                                tail_next   = ptr_inc(tail_reg);
                                count_next  = count_reg + CNT_W'(1);
                                res_next    = make_rsp(ST_OK, '0, count_reg + CNT_W'(1));
                            end
                        end
                        FUNC_DEQUEUE: begin
                            if (count_reg == '0) begin
                                res_next = make_rsp(ST_EMPTY, '0, count_reg);
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = front_reg;
                                state_next  = S_DEQ;
                            end
                        end
                        FUNC_DELETE: begin
                            if (in_handle == '0) begin
                                res_next = make_rsp(ST_NULL, '0, count_reg);
                            end else if (count_reg == '0) begin
                                res_next = make_rsp(ST_ABSENT, '0, count_reg);
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = front_reg;
                                ptr_next    = front_reg;
                                off_next    = '0;
                                state_next  = S_SEARCH;
                            end
                        end
                        default: begin
                            res_next = make_rsp(ST_OK, '0, count_reg);
                        end
                    endcase
                end
            end
            S_DEQ: begin
                front_next = ptr_inc(front_reg);
                count_next = count_dec;
                res_next   = make_rsp(ST_OK, FQD_VALUE_W'(ram_rd_data[KEEP_W-1:0]), count_dec);
                state_next = S_RESP;
            end
            S_SEARCH: begin
                if (ptr_hit) begin
                    if (off_is_last) begin
                        tail_next  = ptr_reg;
                        count_next = count_dec;
                        res_next   = make_rsp(ST_OK, '0, count_dec);
                        state_next = S_RESP;
                    end else begin
                        ram_rd_en   = 1'b1;
                        wr_ptr_next = ptr_reg;
                        ptr_next    = ptr_inc(ptr_reg);
                        off_next    = off_reg + PTR_W'(1);
                        state_next  = S_SHIFT;
                    end
                end else if (off_is_last) begin
                    res_next   = make_rsp(ST_ABSENT, '0, count_reg);
                    state_next = S_RESP;
                end else begin
                    ram_rd_en = 1'b1;
                    ptr_next  = ptr_inc(ptr_reg);
                    off_next  = off_reg + PTR_W'(1);
                end
            end
            S_SHIFT: begin
                ram_wr_en = 1'b1;
                if (off_is_last) begin
                    tail_next  = ptr_reg;
                    count_next = count_dec;
                    res_next   = make_rsp(ST_OK, '0, count_dec);
                    state_next = S_RESP;
                end else begin
                    ram_rd_en   = 1'b1;
                    wr_ptr_next = ptr_reg;
                    ptr_next    = ptr_inc(ptr_reg);
                    off_next    = off_reg + PTR_W'(1);
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        wr_ptr_reg <= wr_ptr_next;
        off_reg    <= off_next;
        handle_reg <= handle_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== rtl/fqd_ram.sv =====
// ----------------------------------------------------------------------------
// fqd_ram: handle store
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module fqd_ram
    import fqd_pkg::*;
#(
    parameter int DEPTH = FQD_DEPTH,
    parameter int WIDTH = FQD_HANDLE_WIDTH
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fqd_checker.sv =====
// ----------------------------------------------------------------------------
// fqd_checker: port-level checks of the handle queue
// Watches the request and result channels for stalls, reset and status consistency.
// ----------------------------------------------------------------------------
module fqd_checker
    import fqd_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input fqd_rsp_t m_data
);

    // A stalled response must hold its contents until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response changed while stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid after reset");

    // Only a successful dequeue returns a handle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.out_value == '0)
        else $error("handle returned with a failing status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |-> m_data.fill_level == '0)
        else $error("empty status with nonzero length");

    // Requests are taken one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken without finishing the first");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (.*);
